>>> design/kpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpc_pkg
// Shared types and constants of the ladder keypad press classifier.
// ----------------------------------------------------------------------------
package kpc_pkg;

  // configuration register indexes
  localparam int CFG_INDEX_BITS = 3;
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LEVEL0_LIMIT     = 3'd0,
    REG_LEVEL1_LIMIT     = 3'd1,
    REG_LEVEL2_LIMIT     = 3'd2,
    REG_LEVEL3_LIMIT     = 3'd3,
    REG_LONG_POLLS       = 3'd4,
    REG_VERY_LONG_POLLS  = 3'd5
  } cfg_reg_t;

  // reset values of the registers
  localparam int LEVEL0_LIMIT_RST    = 20;
  localparam int LEVEL1_LIMIT_RST    = 120;
  localparam int LEVEL2_LIMIT_RST    = 220;
  localparam int LEVEL3_LIMIT_RST    = 320;
  localparam int LONG_POLLS_RST      = 20;
  localparam int VERY_LONG_POLLS_RST = 100;

  // press class codes
  typedef enum logic [1:0] {
    CLASS_SHORT     = 2'd0,
    CLASS_LONG      = 2'd1,
    CLASS_VERY_LONG = 2'd2
  } press_class_t;

  // one result beat
  typedef struct packed {
    logic         key_valid;
    logic [1:0]   key_level;
    press_class_t press_class;
    logic         is_repeat;
  } kpc_result_t;

endpackage

>>> design/adc_ladder_key_press_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_ladder_key_press_classifier_core
// Resistor ladder keypad classifier with short, long and very long press.
// ----------------------------------------------------------------------------
// Takes one ADC sample per cycle while in_stall is low and returns exactly one
// result beat per sample, offered on out_valid once the sample has passed the
// input register and the result register: the sample is registered, then level
// decode, press tracking and the release report are worked out in one pass and
// registered at the output. Throughput is one sample per clock while out_stall
// is low; while a finished result is held by out_stall, the input register
// takes at most one more beat and then in_stall rises until the result is taken.
// key_valid marks a release report; a released poll that directly follows it
// repeats it once with is_repeat set. Write configuration only while idle.
module adc_ladder_key_press_classifier_core
  import kpc_pkg::*;
#(
  parameter int SAMPLE_BITS = 9,
  parameter int COUNT_BITS  = 7,
  localparam int DATA_BITS  = (SAMPLE_BITS > COUNT_BITS) ? SAMPLE_BITS : COUNT_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [DATA_BITS-1:0]      cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [SAMPLE_BITS-1:0]    adc_sample,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      key_valid,
  output logic [1:0]                key_level,
  output logic [1:0]                press_class,
  output logic                      is_repeat
);

  logic [SAMPLE_BITS-1:0] level0_limit;
  logic [SAMPLE_BITS-1:0] level1_limit;
  logic [SAMPLE_BITS-1:0] level2_limit;
  logic [SAMPLE_BITS-1:0] level3_limit;
  logic [COUNT_BITS-1:0]  long_press_polls;
  logic [COUNT_BITS-1:0]  very_long_press_polls;

  logic                   s1_valid;
  logic [SAMPLE_BITS-1:0] s1_sample;
  logic                   advance;
  logic                   step;
  kpc_result_t            result;

  // configuration registers
  kpc_cfg_regs #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .DATA_BITS   (DATA_BITS)
  ) u_cfg (
    .clk                   (clk),
    .rst                   (rst),
    .cfg_write             (cfg_write),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .level0_limit          (level0_limit),
    .level1_limit          (level1_limit),
    .level2_limit          (level2_limit),
    .level3_limit          (level3_limit),
    .long_press_polls      (long_press_polls),
    .very_long_press_polls (very_long_press_polls)
  );

  // pipeline flow control
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign step     = s1_valid && advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_sample <= adc_sample;
    end
  end

  // per poll decode and press tracking
  kpc_tracker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_tracker (
    .clk                   (clk),
    .rst                   (rst),
    .step                  (step),
    .sample                (s1_sample),
    .level0_limit          (level0_limit),
    .level1_limit          (level1_limit),
    .level2_limit          (level2_limit),
    .level3_limit          (level3_limit),
    .long_press_polls      (long_press_polls),
    .very_long_press_polls (very_long_press_polls),
    .result                (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      key_valid   <= result.key_valid;
      key_level   <= result.key_level;
      press_class <= result.press_class;
      is_repeat   <= result.is_repeat;
    end
  end

`ifndef SYNTHESIS
  // a repeat is always a report
  a_repeat_is_report: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_repeat |-> key_valid)
    else $error("repeat beat without key_valid");

  // beats without a report carry zero fields
  a_quiet_beat_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !key_valid |-> key_level == 2'd0 && press_class == 2'd0 && !is_repeat)
    else $error("non-report beat carries data");

  // an accepted sample lands in the input register
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s1_valid)
    else $error("accepted sample lost");

  // a held input beat never drops while the output is stalled
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |=> s1_valid && out_valid)
    else $error("beat dropped under stall");
`endif

endmodule

>>> design/kpc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpc_cfg_regs
// Threshold and press length registers, written through a plain write port.
// ----------------------------------------------------------------------------
module kpc_cfg_regs
  import kpc_pkg::*;
#(
  parameter int SAMPLE_BITS = 9,
  parameter int COUNT_BITS  = 7,
  parameter int DATA_BITS   = 9
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [DATA_BITS-1:0]      cfg_data,
  output logic [SAMPLE_BITS-1:0]    level0_limit,
  output logic [SAMPLE_BITS-1:0]    level1_limit,
  output logic [SAMPLE_BITS-1:0]    level2_limit,
  output logic [SAMPLE_BITS-1:0]    level3_limit,
  output logic [COUNT_BITS-1:0]     long_press_polls,
  output logic [COUNT_BITS-1:0]     very_long_press_polls
);

  logic [SAMPLE_BITS-1:0] sample_value;
  logic [COUNT_BITS-1:0]  count_value;

  // data masked to each register width
  assign sample_value = SAMPLE_BITS'(cfg_data);
  assign count_value  = COUNT_BITS'(cfg_data);

  // register file, unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      level0_limit          <= SAMPLE_BITS'(LEVEL0_LIMIT_RST);
      level1_limit          <= SAMPLE_BITS'(LEVEL1_LIMIT_RST);
      level2_limit          <= SAMPLE_BITS'(LEVEL2_LIMIT_RST);
      level3_limit          <= SAMPLE_BITS'(LEVEL3_LIMIT_RST);
      long_press_polls      <= COUNT_BITS'(LONG_POLLS_RST);
      very_long_press_polls <= COUNT_BITS'(VERY_LONG_POLLS_RST);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LEVEL0_LIMIT:    level0_limit          <= sample_value;
        REG_LEVEL1_LIMIT:    level1_limit          <= sample_value;
        REG_LEVEL2_LIMIT:    level2_limit          <= sample_value;
        REG_LEVEL3_LIMIT:    level3_limit          <= sample_value;
        REG_LONG_POLLS:      long_press_polls      <= count_value;
        REG_VERY_LONG_POLLS: very_long_press_polls <= count_value;
        default: begin
        end
      endcase
    end
  end

endmodule

>>> design/kpc_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpc_tracker
// Ladder level decode, hold tracking and release report for one poll.
// ----------------------------------------------------------------------------
module kpc_tracker
  import kpc_pkg::*;
#(
  parameter int SAMPLE_BITS = 9,
  parameter int COUNT_BITS  = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-1:0] level0_limit,
  input  logic [SAMPLE_BITS-1:0] level1_limit,
  input  logic [SAMPLE_BITS-1:0] level2_limit,
  input  logic [SAMPLE_BITS-1:0] level3_limit,
  input  logic [COUNT_BITS-1:0]  long_press_polls,
  input  logic [COUNT_BITS-1:0]  very_long_press_polls,
  output kpc_result_t            result
);

  logic                  held_valid;
  logic [1:0]            held_level;
  logic [COUNT_BITS-1:0] press_count;
  logic                  repeat_pending;
  logic [1:0]            repeat_level;
  press_class_t          repeat_class;

  logic                  held_valid_next;
  logic [1:0]            held_level_next;
  logic [COUNT_BITS-1:0] press_count_next;
  logic                  repeat_pending_next;
  logic [1:0]            repeat_level_next;
  press_class_t          repeat_class_next;

  logic                  released;
  logic [1:0]            level;
  press_class_t          cls;

  // first threshold above the sample wins
  always_comb begin
    released = 1'b0;
    level    = 2'd0;
    priority if (sample < level0_limit) level = 2'd0;
    else if (sample < level1_limit)     level = 2'd1;
    else if (sample < level2_limit)     level = 2'd2;
    else if (sample < level3_limit)     level = 2'd3;
    else                                released = 1'b1;
  end

  // class from the count before this poll
  always_comb begin
    priority if (press_count > very_long_press_polls) cls = CLASS_VERY_LONG;
    else if (press_count > long_press_polls)          cls = CLASS_LONG;
    else                                              cls = CLASS_SHORT;
  end

  // report and next state
  always_comb begin
    result              = '0;
    result.press_class  = CLASS_SHORT;
    held_valid_next     = held_valid;
    held_level_next     = held_level;
    press_count_next    = press_count;
    repeat_pending_next = repeat_pending;
    repeat_level_next   = repeat_level;
    repeat_class_next   = repeat_class;
    if (released) begin
      if (held_valid) begin
        result.key_valid    = 1'b1;
        result.key_level    = held_level;
        result.press_class  = cls;
        repeat_pending_next = 1'b1;
        repeat_level_next   = held_level;
        repeat_class_next   = cls;
      end else if (repeat_pending) begin
        result.key_valid    = 1'b1;
        result.key_level    = repeat_level;
        result.press_class  = repeat_class;
        result.is_repeat    = 1'b1;
        repeat_pending_next = 1'b0;
      end
      held_valid_next  = 1'b0;
      held_level_next  = 2'd0;
      press_count_next = '0;
    end else begin
      held_valid_next = 1'b1;
      held_level_next = level;
      // saturating poll count
      if (press_count != {COUNT_BITS{1'b1}}) begin
        press_count_next = press_count + COUNT_BITS'(1);
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid     <= 1'b0;
      held_level     <= 2'd0;
      press_count    <= '0;
      repeat_pending <= 1'b0;
      repeat_level   <= 2'd0;
      repeat_class   <= CLASS_SHORT;
    end else if (step) begin
      held_valid     <= held_valid_next;
      held_level     <= held_level_next;
      press_count    <= press_count_next;
      repeat_pending <= repeat_pending_next;
      repeat_level   <= repeat_level_next;
      repeat_class   <= repeat_class_next;
    end
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ladder keypad press classifier core.
// ----------------------------------------------------------------------------
// Sends ADC polls through the valid/stall input channel and checks every
// result beat against a cycle-free model of level decode, press counting and
// release/repeat reporting. Runs a short directed sequence, then press/release
// sequences with random content under several register settings and idle
// patterns, including a long receiver hold-off that backs up the input.
module testbench;
  import kpc_pkg::*;

  // expected-result store and press tracking model
  class press_scoreboard;
    logic [8:0]  level_limit [4];
    logic [6:0]  long_limit;
    logic [6:0]  very_long_limit;
    logic        key_down;
    logic [1:0]  down_level;
    logic [6:0]  poll_count;
    logic        echo_armed;
    logic [1:0]  echo_level;
    press_class_t echo_class;
    kpc_result_t expected_reports [$];
    int          errors;
    int          polls;
    int          reports;
    int          repeats;
    int          long_seen;
    int          very_long_seen;

    function new();
      level_limit[0]  = 9'(LEVEL0_LIMIT_RST);
      level_limit[1]  = 9'(LEVEL1_LIMIT_RST);
      level_limit[2]  = 9'(LEVEL2_LIMIT_RST);
      level_limit[3]  = 9'(LEVEL3_LIMIT_RST);
      long_limit      = 7'(LONG_POLLS_RST);
      very_long_limit = 7'(VERY_LONG_POLLS_RST);
      key_down        = 1'b0;
      down_level      = 2'd0;
      poll_count      = 7'd0;
      echo_armed      = 1'b0;
      echo_level      = 2'd0;
      echo_class      = CLASS_SHORT;
      errors          = 0;
      polls           = 0;
      reports         = 0;
      repeats         = 0;
      long_seen       = 0;
      very_long_seen  = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, int unsigned val);
      case (idx)
        REG_LEVEL0_LIMIT:    level_limit[0] = val[8:0];
        REG_LEVEL1_LIMIT:    level_limit[1] = val[8:0];
        REG_LEVEL2_LIMIT:    level_limit[2] = val[8:0];
        REG_LEVEL3_LIMIT:    level_limit[3] = val[8:0];
        REG_LONG_POLLS:      long_limit = val[6:0];
        REG_VERY_LONG_POLLS: very_long_limit = val[6:0];
        default: ;
      endcase
    endfunction

    // one accepted poll: decode level, track the press, queue the report
    function void note_sample(logic [8:0] sample);
      kpc_result_t  r;
      press_class_t cls;
      logic         released;
      logic [1:0]   lvl;
      r = '0;
      released = 1'b0;
      lvl = 2'd0;
      // class comes from the count before this poll
      if (poll_count > very_long_limit) begin
        cls = CLASS_VERY_LONG;
      end else if (poll_count > long_limit) begin
        cls = CLASS_LONG;
      end else begin
        cls = CLASS_SHORT;
      end
      // first limit above the sample wins, no ordering assumed
      if (sample < level_limit[0]) begin
        lvl = 2'd0;
      end else if (sample < level_limit[1]) begin
        lvl = 2'd1;
      end else if (sample < level_limit[2]) begin
        lvl = 2'd2;
      end else if (sample < level_limit[3]) begin
        lvl = 2'd3;
      end else begin
        released = 1'b1;
      end
      if (released) begin
        if (key_down) begin
          r.key_valid   = 1'b1;
          r.key_level   = down_level;
          r.press_class = cls;
          echo_armed    = 1'b1;
          echo_level    = down_level;
          echo_class    = cls;
        end else if (echo_armed) begin
          r.key_valid   = 1'b1;
          r.key_level   = echo_level;
          r.press_class = echo_class;
          r.is_repeat   = 1'b1;
          echo_armed    = 1'b0;
        end
        key_down   = 1'b0;
        down_level = 2'd0;
        poll_count = 7'd0;
      end else begin
        key_down   = 1'b1;
        down_level = lvl;
        if (poll_count != 7'h7f) poll_count = poll_count + 7'd1;
      end
      expected_reports.push_back(r);
      polls++;
    endfunction

    function void check_result(logic kv, logic [1:0] lvl, logic [1:0] cls, logic rep);
      kpc_result_t e;
      if (expected_reports.size() == 0) begin
        $error("result beat with no poll outstanding");
        errors++;
        return;
      end
      e = expected_reports.pop_front();
      if (kv !== e.key_valid) begin
        $error("key_valid: expected %0d, got %0d", e.key_valid, kv);
        errors++;
      end
      if (lvl !== e.key_level) begin
        $error("key_level: expected %0d, got %0d", e.key_level, lvl);
        errors++;
      end
      if (cls !== e.press_class) begin
        $error("press_class: expected %0d, got %0d", e.press_class, cls);
        errors++;
      end
      if (rep !== e.is_repeat) begin
        $error("is_repeat: expected %0d, got %0d", e.is_repeat, rep);
        errors++;
      end
      if (e.key_valid) begin
        reports++;
        if (e.is_repeat) repeats++;
        if (e.press_class == CLASS_LONG) long_seen++;
        if (e.press_class == CLASS_VERY_LONG) very_long_seen++;
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [8:0] adc_sample = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       key_valid;
  logic [1:0] key_level;
  logic [1:0] press_class;
  logic       is_repeat;

  press_scoreboard sb;
  int          idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_rx = 1'b0;
  int unsigned cur_cfg [6];
  int unsigned directed_polls [17] = '{511, 0, 320, 320, 511, 19, 20, 400,
                                       119, 120, 219, 220, 511, 100, 320, 320, 320};

  adc_ladder_key_press_classifier_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .adc_sample (adc_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .key_valid  (key_valid),
    .key_level  (key_level),
    .press_class(press_class),
    .is_repeat  (is_repeat)
  );

  always #1 clk = ~clk;

  // receiver: random stall, forced high during a hold-off
  always @(posedge clk) begin
    if (hold_rx) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // beat monitor on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_sample(adc_sample);
      if (out_valid && !out_stall) sb.check_result(key_valid, key_level, press_class, is_repeat);
    end
  end

  // offer one poll, with random idle cycles ahead of it
  task automatic send_sample(input int unsigned s);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    adc_sample <= 9'(s);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop offering and wait for every report to come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 9'(val);
    cur_cfg[idx] = val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic apply_config(input int unsigned l0, input int unsigned l1,
                              input int unsigned l2, input int unsigned l3,
                              input int unsigned lp, input int unsigned vlp);
    drain();
    write_reg(REG_LEVEL0_LIMIT, l0);
    write_reg(REG_LEVEL1_LIMIT, l1);
    write_reg(REG_LEVEL2_LIMIT, l2);
    write_reg(REG_LEVEL3_LIMIT, l3);
    write_reg(REG_LONG_POLLS, lp);
    write_reg(REG_VERY_LONG_POLLS, vlp);
    cfg_write <= 1'b0;
  endtask

  // presses of random length and level, releases and some noise
  task automatic run_presses(input int n);
    int sent;
    int top;
    int hold;
    int rel;
    int r;
    sent = 0;
    while (sent < n) begin
      top = 0;
      for (int i = 0; i < 4; i++) begin
        if (cur_cfg[i] > top) top = cur_cfg[i];
      end
      if ($urandom_range(99) < 15 || top == 0) begin
        send_sample($urandom_range(511));
        sent++;
      end else begin
        r = $urandom_range(99);
        if (r < 60) begin
          hold = $urandom_range(8, 1);
        end else if (r < 82) begin
          hold = cur_cfg[REG_LONG_POLLS] + $urandom_range(2);
        end else if (r < 96) begin
          hold = cur_cfg[REG_VERY_LONG_POLLS] + $urandom_range(2);
        end else begin
          hold = $urandom_range(140, 120);
        end
        if (hold == 0) hold = 1;
        rel = $urandom_range(3, 1);
        repeat (hold) send_sample($urandom_range(top - 1));
        repeat (rel) send_sample($urandom_range(511, top));
        sent += hold + rel;
      end
    end
  endtask

  initial begin
    sb = new();
    cur_cfg = '{LEVEL0_LIMIT_RST, LEVEL1_LIMIT_RST, LEVEL2_LIMIT_RST,
                LEVEL3_LIMIT_RST, LONG_POLLS_RST, VERY_LONG_POLLS_RST};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: every level edge, all classes, repeat, pending kept while held
    apply_config(20, 120, 220, 320, 1, 3);
    foreach (directed_polls[i]) send_sample(directed_polls[i]);
    // all limits zero: every poll reads released
    apply_config(0, 0, 0, 0, 0, 126);
    send_sample(0);
    send_sample(511);

    // no idling, reset values; hold-off backs up the input during a saturating press
    apply_config(20, 120, 220, 320, 20, 100);
    fork
      begin
        hold_rx <= 1'b1;
        repeat (60) @(posedge clk);
        hold_rx <= 1'b0;
      end
    join_none
    repeat (135) send_sample($urandom_range(319));
    send_sample(511);
    send_sample($urandom_range(511, 320));
    run_presses(40);

    // sender mostly idle, levels 0..2 empty, press limits at the extremes
    apply_config(0, 0, 0, 511, 0, 126);
    idle_pct = 85;
    run_presses(40);

    // receiver mostly stalling, all limits full, press limits reversed
    apply_config(511, 511, 511, 511, 126, 0);
    idle_pct = 0;
    stall_pct <= 85;
    run_presses(40);

    // light idling on both sides, random and likely unordered limits
    apply_config($urandom_range(511), $urandom_range(511), $urandom_range(511),
                 $urandom_range(511), $urandom_range(126), $urandom_range(126));
    idle_pct = 7;
    stall_pct <= 7;
    run_presses(40);

    drain();
    $display("checked %0d polls: %0d release reports, %0d repeats, %0d long, %0d very long",
             sb.polls, sb.reports, sb.repeats, sb.long_seen, sb.very_long_seen);
    $display("settings covered: zero and full limits, reversed press limits, saturated count");
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin
    #400000;
    $display("timeout with %0d reports outstanding", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
